[rtl/kwdt_pkg.sv]
// ----------------------------------------------------------------------------
// Keyed watchdog timer package
// Shared item and result types, operation and register codes, key values
// and the prescaler divide table.
// ----------------------------------------------------------------------------
package kwdt_pkg;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2
    } t_op;

    localparam logic [1:0] REG_COUNT = 2'd0;
    localparam logic [1:0] REG_CTRL_A = 2'd1;
    localparam logic [1:0] REG_CTRL_B = 2'd2;

    localparam logic [15:0] KEY_COUNT = 16'h5a5a;
    localparam logic [23:0] KEY_CONTROL = 24'ha5a5a5;

    localparam int PRESCALE_BITS = 12;
    localparam int READ_BITS = 16;

    // Output tuser bit positions.
    localparam int TUSER_TIMEOUT = 0;
    localparam int TUSER_REJECT = 1;

    typedef struct packed {
        logic [1:0]  operation;
        logic [1:0]  reg_select;
        logic [31:0] write_data;
    } t_item;

    typedef struct packed {
        logic [READ_BITS-1:0] read_data;
        logic                 timeout_pulse;
        logic                 write_rejected;
    } t_result;

    // Prescaler terminal count for each divider select code.
    function automatic logic [PRESCALE_BITS:0] div_limit(input logic [2:0] sel);
        logic [PRESCALE_BITS:0] lim;
        case (sel)
            3'd0:    lim = 13'd1;
            3'd1:    lim = 13'd4;
            3'd2:    lim = 13'd16;
            3'd3:    lim = 13'd32;
            3'd4:    lim = 13'd64;
            3'd5:    lim = 13'd128;
            3'd6:    lim = 13'd1024;
            default: lim = 13'd4096;
        endcase
        return lim;
    endfunction

endpackage

[rtl/kwdt_exec.sv]
// ----------------------------------------------------------------------------
// Keyed watchdog execution unit
// Holds the watchdog state and executes one tick, write or read request
// per cycle in which i_fire is high, producing its result combinationally.
// ----------------------------------------------------------------------------
module kwdt_exec #(
    parameter int COUNTER_BITS = 16,
    parameter int WRITE_SYNC_TICKS = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  kwdt_pkg::t_item   i_item,
    output kwdt_pkg::t_result o_result
);
    import kwdt_pkg::*;

    localparam logic [1:0] SYNC_TICKS = 2'(WRITE_SYNC_TICKS);

    logic [COUNTER_BITS-1:0]  r_count, n_count;
    logic [PRESCALE_BITS-1:0] r_prescale, n_prescale;
    logic [2:0]               r_div_sel, n_div_sel;
    logic                     r_enable, n_enable;
    logic [7:0]               r_ctrl_b, n_ctrl_b;
    logic [1:0]               r_busy, n_busy;

    logic [PRESCALE_BITS:0]   pre_next;
    logic [COUNTER_BITS-1:0]  count_inc;
    logic                     key_count_ok;
    logic                     key_ctrl_ok;
    logic [READ_BITS-1:0]     count_rd;
    t_op                      op;

    assign op = t_op'(i_item.operation);
    assign pre_next = {1'b0, r_prescale} + 1'b1;
    assign count_inc = r_count + 1'b1;
    assign key_count_ok = (i_item.write_data[31:16] == KEY_COUNT);
    assign key_ctrl_ok = (i_item.write_data[31:8] == KEY_CONTROL);

    generate
        if (COUNTER_BITS >= READ_BITS) begin : g_rd_wide
            assign count_rd = r_count[READ_BITS-1:0];
        end else begin : g_rd_narrow
            assign count_rd = {{(READ_BITS-COUNTER_BITS){1'b0}}, r_count};
        end
    endgenerate

    always_comb begin
        n_count = r_count;
        n_prescale = r_prescale;
        n_div_sel = r_div_sel;
        n_enable = r_enable;
        n_ctrl_b = r_ctrl_b;
        n_busy = r_busy;
        o_result = '0;
        case (op)
            OP_TICK: begin
                if (r_busy != 2'd0) begin
                    n_busy = r_busy - 2'd1;
                end
                if (r_enable) begin
                    if (pre_next >= div_limit(r_div_sel)) begin
                        n_prescale = '0;
                        n_count = count_inc;
                        o_result.timeout_pulse = (count_inc == '0);
                    end else begin
                        n_prescale = pre_next[PRESCALE_BITS-1:0];
                    end
                end
            end
            OP_WRITE: begin
                case (i_item.reg_select)
                    REG_COUNT: begin
                        if (key_count_ok) begin
                            n_count = i_item.write_data[COUNTER_BITS-1:0];
                            n_prescale = '0;
                            n_busy = SYNC_TICKS;
                        end else begin
                            o_result.write_rejected = 1'b1;
                        end
                    end
                    REG_CTRL_A: begin
                        if (key_ctrl_ok) begin
                            n_div_sel = i_item.write_data[2:0];
                            n_enable = i_item.write_data[7];
                            n_prescale = '0;
                            n_busy = SYNC_TICKS;
                        end else begin
                            o_result.write_rejected = 1'b1;
                        end
                    end
                    REG_CTRL_B: begin
                        if (key_ctrl_ok) begin
                            n_ctrl_b = i_item.write_data[7:0];
                            n_busy = SYNC_TICKS;
                        end else begin
                            o_result.write_rejected = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            OP_READ: begin
                case (i_item.reg_select)
                    REG_COUNT: o_result.read_data = count_rd;
                    REG_CTRL_A: o_result.read_data =
                        {8'd0, r_enable, 1'b0, (r_busy != 2'd0), 2'b00, r_div_sel};
                    REG_CTRL_B: o_result.read_data = {8'd0, r_ctrl_b};
                    default: o_result.read_data = '0;
                endcase
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_prescale <= '0;
            r_div_sel <= '0;
            r_enable <= 1'b0;
            r_ctrl_b <= '0;
            r_busy <= '0;
        end else if (i_fire) begin
            r_count <= n_count;
            r_prescale <= n_prescale;
            r_div_sel <= n_div_sel;
            r_enable <= n_enable;
            r_ctrl_b <= n_ctrl_b;
            r_busy <= n_busy;
        end
    end

endmodule

[rtl/keyed_watchdog_timer_core.sv]
// ----------------------------------------------------------------------------
// Keyed watchdog timer core
// A request goes from the input register through the execution unit into the
// result register. Throughput: one request per cycle while the output is not
// stalled by m_axis_tready, set by the combinational next-state logic of the
// execution unit. Synchronous active-low reset clears the counter, prescaler,
// control registers and busy time.
module keyed_watchdog_timer_core #(
    parameter int COUNTER_BITS = 16,
    parameter int WRITE_SYNC_TICKS = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] write_data
    input  logic [3:0]  s_axis_tuser,   // [1:0] operation, [3:2] reg_select
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] read_data
    output logic [1:0]  m_axis_tuser    // [0] timeout_pulse, [1] write_rejected
);
    import kwdt_pkg::*;

    logic    r_in_valid;
    t_item   r_item;
    logic    r_out_valid;
    t_result r_result;
    t_result exec_result;
    logic    advance;
    logic    exec_fire;

    assign advance = !r_out_valid || m_axis_tready;
    assign s_axis_tready = advance || !r_in_valid;
    assign exec_fire = r_in_valid && advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_item.operation <= s_axis_tuser[1:0];
            r_item.reg_select <= s_axis_tuser[3:2];
            r_item.write_data <= s_axis_tdata;
        end
    end

    kwdt_exec #(
        .COUNTER_BITS(COUNTER_BITS),
        .WRITE_SYNC_TICKS(WRITE_SYNC_TICKS)
    ) u_exec (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_fire(exec_fire),
        .i_item(r_item),
        .o_result(exec_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec_fire) begin
            r_result <= exec_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata = r_result.read_data;
    assign m_axis_tuser[TUSER_TIMEOUT] = r_result.timeout_pulse;
    assign m_axis_tuser[TUSER_REJECT] = r_result.write_rejected;

    // A timeout only comes from a tick, which never carries read data.
    a_timeout_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[TUSER_TIMEOUT]) |-> (m_axis_tdata == 16'd0))
        else $error("timeout result carries read data");

    // A result never flags both a tick overflow and a rejected write.
    a_pulse_reject_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[TUSER_TIMEOUT] && m_axis_tuser[TUSER_REJECT]))
        else $error("timeout and reject flagged together");

    // With the result register empty, the input side must take a request.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> s_axis_tready)
        else $error("input stalled with empty result register");

    // An executed request always shows up as a result on the next cycle.
    a_exec_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        exec_fire |=> r_out_valid)
        else $error("executed request lost");

endmodule
